// File: rtl/link_ready_frame_parser_macros.svh
// Assertion macros for the link ready frame parser.
// Included by the top level only; no other dependencies.
`ifndef LINK_READY_FRAME_PARSER_MACROS_SVH
`define LINK_READY_FRAME_PARSER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LRFP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lrfp assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LRFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lrfp assertion failed");

`endif

// File: rtl/lrfp_pkg.sv
// Shared types and constants of the link ready frame parser.
// Used by lrfp_core, lrfp_out and the top level; no dependencies.
`timescale 1ns / 1ps
package lrfp_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MAGIC   = 2'd0;
    localparam logic [1:0] CFG_RTYPE   = 2'd1;
    localparam logic [1:0] CFG_PERIOD  = 2'd2;
    localparam logic [1:0] CFG_TIMEOUT = 2'd3;

    localparam logic [7:0]  MAGIC_RST   = 8'd170;
    localparam logic [7:0]  RTYPE_RST   = 8'd1;
    localparam logic [15:0] PERIOD_RST  = 16'd2000;
    localparam logic [31:0] TIMEOUT_RST = 32'd90000;

    localparam logic [7:0] HELLO_TYPE = 8'hFE;
    localparam logic [7:0] HELLO_LEN  = 8'h00;

    // Position of a result within a heartbeat burst.
    localparam logic [1:0] BEAT_MAGIC = 2'd0;
    localparam logic [1:0] BEAT_TYPE  = 2'd1;
    localparam logic [1:0] BEAT_LEN   = 2'd2;

    localparam logic OP_BYTE = 1'b0;

    // Result of one transaction as handed from the core to the output stage.
    typedef struct packed {
        logic       hb;
        logic [7:0] magic;
        logic       set;
        logic       ready;
    } t_res;

endpackage

// File: rtl/lrfp_core.sv
// Frame parser, tick counters and configuration registers.
// Depends on lrfp_pkg.
`timescale 1ns / 1ps
module lrfp_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  logic [31:0]   i_cfg_data,
    input  logic          i_accept,
    input  logic          i_operation,
    input  logic [7:0]    i_rx_byte,
    output lrfp_pkg::t_res o_res
);
    import lrfp_pkg::*;

    typedef enum logic [1:0] {
        PH_MAGIC   = 2'd0,
        PH_TYPE    = 2'd1,
        PH_LEN     = 2'd2,
        PH_PAYLOAD = 2'd3
    } t_phase;

    logic [7:0]  r_magic, r_rtype;
    logic [15:0] r_period;
    logic [31:0] r_timeout;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_type, n_type;
    logic [7:0]  r_left, n_left;
    logic        r_ready, n_ready;
    logic [15:0] r_hello, n_hello;
    logic [31:0] r_start, n_start;

    logic        done;
    logic        set;
    logic        hb;
    logic [7:0]  left_dec;

    assign left_dec = r_left - 8'd1;

    always_comb begin
        n_phase = r_phase;
        n_type  = r_type;
        n_left  = r_left;
        n_ready = r_ready;
        n_hello = r_hello;
        n_start = r_start;
        done    = 1'b0;
        set     = 1'b0;
        hb      = 1'b0;
        if (i_operation == OP_BYTE) begin
            case (r_phase)
                PH_MAGIC: begin
                    if (i_rx_byte == r_magic) n_phase = PH_TYPE;
                end
                PH_TYPE: begin
                    n_type  = i_rx_byte;
                    n_phase = PH_LEN;
                end
                PH_LEN: begin
                    n_left = i_rx_byte;
                    if (i_rx_byte == 8'd0) done = 1'b1;
                    else n_phase = PH_PAYLOAD;
                end
                default: begin
                    n_left = left_dec;
                    if (left_dec == 8'd0) done = 1'b1;
                end
            endcase
            if (done) begin
                n_phase = PH_MAGIC;
                if (r_type == r_rtype && !r_ready) begin
                    n_ready = 1'b1;
                    set     = 1'b1;
                end
            end
        end else begin
            if (r_start != '1) n_start = r_start + 32'd1;
            if (!r_ready) begin
                if (r_hello != '1) n_hello = r_hello + 16'd1;
                if (n_hello >= r_period) begin
                    hb      = 1'b1;
                    n_hello = 16'd0;
                end
                if (n_start >= r_timeout) begin
                    n_ready = 1'b1;
                    set     = 1'b1;
                end
            end
        end
    end

    assign o_res.hb    = hb;
    assign o_res.magic = r_magic;
    assign o_res.set   = set;
    assign o_res.ready = n_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic   <= MAGIC_RST;
            r_rtype   <= RTYPE_RST;
            r_period  <= PERIOD_RST;
            r_timeout <= TIMEOUT_RST;
            r_phase   <= PH_MAGIC;
            r_type    <= 8'd0;
            r_left    <= 8'd0;
            r_ready   <= 1'b0;
            r_hello   <= 16'd0;
            r_start   <= 32'd0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MAGIC:   r_magic   <= i_cfg_data[7:0];
                    CFG_RTYPE:   r_rtype   <= i_cfg_data[7:0];
                    CFG_PERIOD:  r_period  <= i_cfg_data[15:0];
                    CFG_TIMEOUT: r_timeout <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_accept) begin
                r_phase <= n_phase;
                r_type  <= n_type;
                r_left  <= n_left;
                r_ready <= n_ready;
                r_hello <= n_hello;
                r_start <= n_start;
            end
        end
    end

endmodule

// File: rtl/lrfp_out.sv
// Result register that plays out one or three results per transaction.
// Depends on lrfp_pkg.
`timescale 1ns / 1ps
module lrfp_out (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  lrfp_pkg::t_res i_res,
    input  logic           i_out_stall,
    output logic           o_in_stall,
    output logic           o_out_valid,
    output logic           o_has_tx_byte,
    output logic [7:0]     o_tx_byte,
    output logic           o_ready_res,
    output logic           o_became_ready,
    output logic           o_last
);
    import lrfp_pkg::*;

    logic       r_valid;
    logic [1:0] r_beat;
    t_res       r_res;
    logic       last;
    logic       take;

    assign last = !r_res.hb || (r_beat == BEAT_LEN);
    assign take = r_valid && !i_out_stall;

    // A new transaction may enter whenever the final result leaves this cycle.
    assign o_in_stall = r_valid && !(take && last);

    always_comb begin
        o_tx_byte = 8'd0;
        if (r_res.hb) begin
            case (r_beat)
                BEAT_MAGIC: o_tx_byte = r_res.magic;
                BEAT_TYPE:  o_tx_byte = HELLO_TYPE;
                default:    o_tx_byte = HELLO_LEN;
            endcase
        end
    end

    assign o_out_valid    = r_valid;
    assign o_has_tx_byte  = r_res.hb;
    assign o_ready_res    = r_res.ready;
    assign o_became_ready = r_res.set;
    assign o_last         = last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_beat  <= BEAT_MAGIC;
        end else if (i_accept) begin
            r_valid <= 1'b1;
            r_beat  <= BEAT_MAGIC;
        end else if (take) begin
            if (last) r_valid <= 1'b0;
            else r_beat <= r_beat + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) r_res <= i_res;
    end

endmodule

// File: rtl/link_ready_frame_parser.sv
// Link ready frame parser: receive frame parsing, heartbeat and ready timeout.
// Each input transaction carries a received byte (operation 0) or a one
// millisecond tick (operation 1). Both channels use valid and stall.
// A transaction is processed in the cycle it is accepted, and its first result
// is presented from the result register in the next cycle.
// A received byte or a quiet tick yields one result, so one transaction per
// cycle is sustained while the receiver does not stall. A tick that fires the
// heartbeat yields three results (magic, 0xFE, 0x00), and the input is stalled
// while the result register plays them out.
// The input is taken again in the same cycle the final result is accepted.
// When the receiver stalls, the current result holds and the input stalls.
// Reset is synchronous and active low: the parser waits for the magic byte,
// counters and ready clear, and registers return to 0xAA, 1, 2000 and 90000.
// Configuration writes take effect at the clock edge of the write enable.
// Depends on lrfp_pkg, lrfp_core, lrfp_out and the macros header.
`timescale 1ns / 1ps
module link_ready_frame_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_operation,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_has_tx_byte,
    output logic [7:0]  o_tx_byte,
    output logic        o_ready_res,
    output logic        o_became_ready,
    output logic        o_last
);
    import lrfp_pkg::*;

`include "link_ready_frame_parser_macros.svh"

    logic accept;
    t_res res;

    assign accept = i_in_valid && !o_in_stall;

    lrfp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_operation (i_operation),
        .i_rx_byte   (i_rx_byte),
        .o_res       (res)
    );

    lrfp_out u_out (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_res          (res),
        .i_out_stall    (i_out_stall),
        .o_in_stall     (o_in_stall),
        .o_out_valid    (o_out_valid),
        .o_has_tx_byte  (o_has_tx_byte),
        .o_tx_byte      (o_tx_byte),
        .o_ready_res    (o_ready_res),
        .o_became_ready (o_became_ready),
        .o_last         (o_last)
    );

    // Only heartbeat bursts have results before the last one.
    `LRFP_ASSERT_IMP(a_burst_has_tx, i_clk, i_rst_n, o_out_valid && !o_last, o_has_tx_byte)
    // A transaction that set ready reports ready.
    `LRFP_ASSERT_IMP(a_set_ready, i_clk, i_rst_n, o_out_valid && o_became_ready, o_ready_res)
    // A burst keeps the result register busy until its last result.
    `LRFP_ASSERT_NEXT(a_burst_cont, i_clk, i_rst_n,
        o_out_valid && !i_out_stall && !o_last, o_out_valid && o_has_tx_byte)

endmodule
